@@ src/frt_pkg.sv @@
// Shared types and constants of the fragment reassembly tracker.
`timescale 1ns / 1ps
`default_nettype none

package frt_pkg;

    localparam int IMG_W   = 16;
    localparam int FRAG_W  = 16;
    localparam int SIZE_W  = 21;
    localparam int LEN_W   = 14;
    localparam int COUNT_W = 32;
    // Wide enough for the largest buffer size and for a byte count plus a payload length.
    localparam int CMP_W   = 25;

    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 80;

    typedef enum logic [1:0] {
        OP_FRAGMENT = 2'd0,
        OP_START    = 2'd1,
        OP_STOP     = 2'd2,
        OP_RELEASE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        MODE_CLOSED = 2'd0,
        MODE_UNSYNC = 2'd1,
        MODE_SYNC   = 2'd2
    } mode_t;

    typedef enum logic [3:0] {
        ST_FIRST     = 4'd0,
        ST_NEXT      = 4'd1,
        ST_DUPLICATE = 4'd2,
        ST_UNSYNCED  = 4'd3,
        ST_ORDER     = 4'd4,
        ST_OVERSIZE  = 4'd5,
        ST_CLOSED    = 4'd6,
        ST_DONE      = 4'd7,
        ST_REJECTED  = 4'd8
    } status_t;

    typedef struct packed {
        op_t                operation;
        logic [IMG_W-1:0]   image_number;
        logic [FRAG_W-1:0]  fragment_number;
        logic [SIZE_W-1:0]  total_size;
        logic [LEN_W-1:0]   fragment_length;
    } item_t;

    typedef struct packed {
        status_t             status;
        logic [SIZE_W-1:0]   write_offset;
        logic [SIZE_W-1:0]   bytes_received;
        logic                image_complete;
        logic [COUNT_W-1:0]  frames_completed;
        mode_t               mode;
    } result_t;

endpackage

`default_nettype wire

@@ src/frt_core.sv @@
// Reassembly state and the per-header check and update logic.
`timescale 1ns / 1ps
`default_nettype none

module frt_core import frt_pkg::*; #(
    parameter int MAX_FRAGMENT_BYTES = 8192,
    parameter int BUFFER_BYTES       = 1048576
) (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire item_t   item,
    input  wire logic    advance,
    output result_t      result
);

    localparam logic [SIZE_W-1:0] COUNT_MAX = {SIZE_W{1'b1}};
    localparam logic [CMP_W-1:0]  BUF_LIMIT = CMP_W'(BUFFER_BYTES);
    localparam logic [CMP_W-1:0]  LEN_LIMIT = CMP_W'(MAX_FRAGMENT_BYTES);

    mode_t               mode_reg, mode_next;
    logic [IMG_W-1:0]    image_reg, image_next;
    logic [FRAG_W-1:0]   last_reg, last_next;
    logic [SIZE_W-1:0]   bytes_reg, bytes_next;
    logic [COUNT_W-1:0]  done_cnt_reg, done_cnt_next;

    logic [LEN_W-1:0]    len;
    logic [SIZE_W-1:0]   base;
    logic [SIZE_W:0]     end_sum;
    logic                fits;
    logic [SIZE_W-1:0]   end_sat;
    logic                fnum_is_next;

    always_comb begin
        // Payloads longer than the receive limit are cut to it.
        if (CMP_W'(item.fragment_length) > LEN_LIMIT) begin
            len = LEN_W'(MAX_FRAGMENT_BYTES);
        end else begin
            len = item.fragment_length;
        end
        base    = (item.fragment_number == '0) ? '0 : bytes_reg;
        end_sum = {1'b0, base} + (SIZE_W + 1)'(len);
        fits    = CMP_W'(end_sum) <= BUF_LIMIT;
        end_sat = end_sum[SIZE_W] ? COUNT_MAX : end_sum[SIZE_W-1:0];
        // The fragment number does not wrap past its largest value.
        fnum_is_next = {1'b0, item.fragment_number} == ({1'b0, last_reg} + 1'b1);
    end

    always_comb begin
        mode_next     = mode_reg;
        image_next    = image_reg;
        last_next     = last_reg;
        bytes_next    = bytes_reg;
        done_cnt_next = done_cnt_reg;
        result.status         = ST_REJECTED;
        result.write_offset   = '0;
        result.image_complete = 1'b0;

        case (item.operation)
            OP_START: begin
                if (mode_reg == MODE_CLOSED) begin
                    mode_next     = MODE_UNSYNC;
                    done_cnt_next = '0;
                    result.status = ST_DONE;
                end
            end
            OP_STOP: begin
                if (mode_reg != MODE_CLOSED) begin
                    mode_next     = MODE_CLOSED;
                    result.status = ST_DONE;
                end
            end
            OP_RELEASE: begin
                if (mode_reg != MODE_CLOSED && done_cnt_reg != '0) begin
                    mode_next     = MODE_UNSYNC;
                    result.status = ST_DONE;
                end
            end
            OP_FRAGMENT: begin
                if (mode_reg == MODE_CLOSED) begin
                    result.status = ST_CLOSED;
                end else begin
                    if (mode_reg != MODE_SYNC) begin
                        bytes_next = '0;
                    end
                    if (item.fragment_number == '0) begin
                        if (mode_reg == MODE_SYNC && image_reg == item.image_number) begin
                            result.status = ST_DUPLICATE;
                        end else if (CMP_W'(item.total_size) > BUF_LIMIT) begin
                            mode_next     = MODE_UNSYNC;
                            bytes_next    = '0;
                            result.status = ST_OVERSIZE;
                        end else begin
                            image_next = item.image_number;
                            last_next  = '0;
                            if (fits) begin
                                mode_next           = MODE_SYNC;
                                bytes_next          = end_sat;
                                result.status       = ST_FIRST;
                                result.write_offset = base;
                            end else begin
                                mode_next     = MODE_UNSYNC;
                                bytes_next    = '0;
                                result.status = ST_OVERSIZE;
                            end
                        end
                    end else if (mode_reg != MODE_SYNC) begin
                        result.status = ST_UNSYNCED;
                    end else if (item.image_number != image_reg || !fnum_is_next) begin
                        result.status = ST_ORDER;
                    end else if (fits) begin
                        last_next           = item.fragment_number;
                        bytes_next          = end_sat;
                        result.status       = ST_NEXT;
                        result.write_offset = base;
                    end else begin
                        mode_next     = MODE_UNSYNC;
                        bytes_next    = '0;
                        result.status = ST_OVERSIZE;
                    end
                    if ((result.status == ST_FIRST || result.status == ST_NEXT)
                            && end_sat == item.total_size) begin
                        result.image_complete = 1'b1;
                        done_cnt_next         = done_cnt_reg + 1'b1;
                    end
                end
            end
            default: begin
                result.status = ST_REJECTED;
            end
        endcase

        result.bytes_received   = bytes_next;
        result.frames_completed = done_cnt_next;
        result.mode             = mode_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= MODE_CLOSED;
            image_reg    <= '0;
            last_reg     <= '0;
            bytes_reg    <= '0;
            done_cnt_reg <= '0;
        end else if (advance) begin
            mode_reg     <= mode_next;
            image_reg    <= image_next;
            last_reg     <= last_next;
            bytes_reg    <= bytes_next;
            done_cnt_reg <= done_cnt_next;
        end
    end

endmodule

`default_nettype wire

@@ src/fragment_reassembly_tracker_top.sv @@
// Top level of the fragment reassembly tracker: input register, core and result register.
//
// The block takes one fragment header or control operation per transfer and returns one
// result transfer for each, in order. With the result side ready it accepts a transfer in
// every cycle; a result passes through the input register and then the result register.
// The update of the tracking state in the core sets that rate: the check of each header
// and the one payload add are done before the next header reaches the core. A stalled
// result register holds its transfer while the input register still takes one more.
`timescale 1ns / 1ps
`default_nettype none

module fragment_reassembly_tracker_top import frt_pkg::*; #(
    parameter int MAX_FRAGMENT_BYTES = 8192,
    parameter int BUFFER_BYTES       = 1048576
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // image_number[15:0], fragment_number[31:16], total_size[52:32], fragment_length[66:53]
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    // operation[1:0]
    input  wire logic [1:0]            s_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // write_offset[20:0], bytes_received[41:21], image_complete[42],
    // frames_completed[74:43], mode[76:75]
    output logic [M_TDATA_W-1:0]       m_tdata,
    // status[3:0]
    output logic [3:0]                 m_tuser
);

    logic     in_valid_reg;
    item_t    in_item_reg;
    logic     out_valid_reg;
    result_t  out_res_reg;
    result_t  core_res;
    logic     advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_item_reg.operation       <= op_t'(s_tuser);
            in_item_reg.image_number    <= s_tdata[15:0];
            in_item_reg.fragment_number <= s_tdata[31:16];
            in_item_reg.total_size      <= s_tdata[52:32];
            in_item_reg.fragment_length <= s_tdata[66:53];
        end
        if (advance) begin
            out_res_reg <= core_res;
        end
    end

    frt_core #(
        .MAX_FRAGMENT_BYTES (MAX_FRAGMENT_BYTES),
        .BUFFER_BYTES       (BUFFER_BYTES)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .item    (in_item_reg),
        .advance (advance),
        .result  (core_res)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.status;
    assign m_tdata  = {3'b000,
                       out_res_reg.mode,
                       out_res_reg.frames_completed,
                       out_res_reg.image_complete,
                       out_res_reg.bytes_received,
                       out_res_reg.write_offset};

endmodule

`default_nettype wire

@@ src/frt_checker.sv @@
// Port-level checks of the fragment reassembly tracker, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none

module frt_checker import frt_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic [M_TDATA_W-1:0]  m_tdata,
    input  wire logic [3:0]            m_tuser
);

    // A result held back by the sink keeps its content.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result transfer changed");

    // A completed image is only reported for a taken payload, which leaves the block synced.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[42] |->
            (m_tuser == ST_FIRST || m_tuser == ST_NEXT) && m_tdata[76:75] == MODE_SYNC)
        else $error("image completion without a taken fragment");

    // A fragment refused because the block is closed leaves it closed.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == ST_CLOSED |-> m_tdata[76:75] == MODE_CLOSED)
        else $error("closed refusal with an open mode");

    // Oversize drops the image and clears the byte count.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == ST_OVERSIZE |->
            m_tdata[76:75] == MODE_UNSYNC && m_tdata[41:21] == '0 && m_tdata[20:0] == '0)
        else $error("oversize result did not drop the image");

endmodule

bind fragment_reassembly_tracker_top frt_checker u_frt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
